@@ rtl/assert_macros.svh @@
// Assertion macros for the merge block RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, cond, expct) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expct)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expct) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expct)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, cond, expct)
`define ASSERT_NEXT(label, clk, rst_n, cond, expct)

`endif

`endif

@@ rtl/kmdc_pkg.sv @@
// Shared types and constants for the k-way merge with duplicate combine.
// No dependencies; imported by the head memory and the top level.
`default_nettype none

package kmdc_pkg;

  localparam int unsigned DEF_WAYS    = 8;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned CNT_W       = 64;
  localparam int unsigned WAY_W       = 3;
  localparam int unsigned LIMIT_W     = 32;
  localparam int unsigned MASK_W      = 8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  // Input item opcodes
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  // One way head as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0] major;
    logic [KEY_W-1:0] minor;
    logic [CNT_W-1:0] tally;
  } head_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EVAL   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/kway_merge_dedup_count.sv @@
// K-way merge of sorted (major key, minor key, count) streams, equal keys combined.
// Depends on kmdc_pkg, kmdc_head_mem and assert_macros.svh.
//
//  channel | signals                                        | direction
//  in      | in_valid/in_ready, in_func, in_way, keys, count | push head or close way
//  out     | out_valid/out_ready, keys, count, mask, flags  | one merged item or done
//  cfg     | cfg_we, cfg_wdata                              | result limit write
//
// An item that completes the set of heads steps through accept, evaluate, one head
// read per cycle from the single read port of the head memory, a fold of the last
// head and retire. Other items: accept and evaluate; after done, items are dropped.
// rst_n is synchronous; it clears control state, the head memory is not cleared.
// A result waits in the output register while new items are accepted; a result due
// while that register is occupied holds the sequencer in evaluate or retire.
`default_nettype none

`include "assert_macros.svh"

module kway_merge_dedup_count #(
  parameter int unsigned WAYS = kmdc_pkg::DEF_WAYS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic                          in_func,
  input  wire logic [kmdc_pkg::WAY_W-1:0]    in_way,
  input  wire logic [kmdc_pkg::KEY_W-1:0]    in_major_key,
  input  wire logic [kmdc_pkg::KEY_W-1:0]    in_minor_key,
  input  wire logic [kmdc_pkg::CNT_W-1:0]    in_entry_count,
  // result channel
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [kmdc_pkg::KEY_W-1:0]    out_major_key,
  output      logic [kmdc_pkg::KEY_W-1:0]    out_minor_key,
  output      logic [kmdc_pkg::CNT_W-1:0]    out_count,
  output      logic [kmdc_pkg::MASK_W-1:0]   out_refill_mask,
  output      logic                          out_done_res,
  output      logic                          out_has_entry,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [kmdc_pkg::LIMIT_W-1:0]  cfg_wdata
);
  import kmdc_pkg::*;

  localparam int unsigned IDX_W = $clog2(WAYS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WAYS - 1);

  // Control state
  state_t               st_r, st_nxt;
  logic [WAYS-1:0]      valid_r, valid_nxt;
  logic [WAYS-1:0]      closed_r, closed_nxt;
  logic [LIMIT_W-1:0]   emitted_r, emitted_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic                 fin_r, fin_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]     p_idx_r, p_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Running minimum
  logic                 found_r, found_nxt;
  logic [KEY_W-1:0]     ml_r, ml_nxt;
  logic [KEY_W-1:0]     mr_r, mr_nxt;
  logic [CNT_W-1:0]     sum_r, sum_nxt;
  logic [WAYS-1:0]      taken_r, taken_nxt;

  // Output payload
  logic [KEY_W-1:0]     out_kl_r, out_kr_r;
  logic [CNT_W-1:0]     out_cnt_r;
  logic [MASK_W-1:0]    out_mask_r;
  logic                 out_done_r, out_has_r;

  // Result to load
  logic                 load;
  logic [KEY_W-1:0]     res_kl, res_kr;
  logic [CNT_W-1:0]     res_cnt;
  logic [MASK_W-1:0]    res_mask;
  logic                 res_done, res_has;

  // Input decode
  logic                 in_fire;
  logic                 way_ok;
  logic [IDX_W-1:0]     way_idx;
  logic [WAYS-1:0]      way_bit;
  logic                 push_ok;
  head_t                wr_head;
  head_t                rd_head;

  // Merge helpers
  logic                 slot_free;
  logic                 lim_hit;
  logic                 all_closed;
  logic                 pick_ok;
  logic                 head_less;
  logic                 head_eq;
  logic [CNT_W:0]       sum_wide;
  logic [CNT_W-1:0]     sum_sat;
  logic [WAYS-1:0]      p_bit;
  logic [WAYS-1:0]      valid_left;
  logic [LIMIT_W:0]     emit_inc;
  logic                 fin_after;
  logic [WAYS-1:0]      mask_w;

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign way_ok    = (32'(in_way) < 32'(WAYS));
  assign way_idx   = IDX_W'(in_way);
  assign way_bit   = way_ok ? (WAYS'(1) << way_idx) : '0;
  assign push_ok   = in_fire && !fin_r && way_ok && (in_func == FUNC_PUSH) &&
                     !closed_r[way_idx] && !valid_r[way_idx];

  assign wr_head = '{major: in_major_key, minor: in_minor_key, tally: in_entry_count};

  kmdc_head_mem #(
    .DEPTH (WAYS)
  ) u_head_mem (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (way_idx),
    .wr_data (wr_head),
    .rd_en   (st_r == ST_SCAN),
    .rd_addr (rd_idx_r),
    .rd_data (rd_head)
  );

  // Merge conditions on the committed state
  assign slot_free  = !out_valid_r || out_ready;
  assign lim_hit    = (emitted_r >= limit_r);
  assign all_closed = &closed_r;
  assign pick_ok    = (&(valid_r | closed_r)) && (|valid_r);

  // Compare and combine one head against the running minimum
  assign head_less = (rd_head.major < ml_r) ||
                     ((rd_head.major == ml_r) && (rd_head.minor < mr_r));
  assign head_eq   = (rd_head.major == ml_r) && (rd_head.minor == mr_r);
  assign sum_wide  = {1'b0, sum_r} + {1'b0, rd_head.tally};
  assign sum_sat   = sum_wide[CNT_W] ? '1 : sum_wide[CNT_W-1:0];
  assign p_bit     = WAYS'(1) << p_idx_r;

  // Retire terms
  assign valid_left = valid_r & ~taken_r;
  assign emit_inc   = {1'b0, emitted_r} + (LIMIT_W+1)'(1);
  assign fin_after  = (emit_inc >= {1'b0, limit_r}) || (all_closed && !(|valid_left));
  assign mask_w     = taken_r & ~closed_r;

  // Sequencer
  always_comb begin
    st_nxt      = st_r;
    valid_nxt   = valid_r;
    closed_nxt  = closed_r;
    emitted_nxt = emitted_r;
    fin_nxt     = fin_r;
    rd_idx_nxt  = rd_idx_r;
    p_vld_nxt   = p_vld_r;
    p_idx_nxt   = p_idx_r;
    found_nxt   = found_r;
    ml_nxt      = ml_r;
    mr_nxt      = mr_r;
    sum_nxt     = sum_r;
    taken_nxt   = taken_r;
    load        = 1'b0;
    res_kl      = '0;
    res_kr      = '0;
    res_cnt     = '0;
    res_mask    = '0;
    res_done    = 1'b0;
    res_has     = 1'b0;

    // Fold the head read last cycle
    if ((st_r == ST_SCAN || st_r == ST_DRAIN) && p_vld_r && valid_r[p_idx_r]) begin
      if (!found_r || head_less) begin
        found_nxt = 1'b1;
        ml_nxt    = rd_head.major;
        mr_nxt    = rd_head.minor;
        sum_nxt   = rd_head.tally;
        taken_nxt = p_bit;
      end else if (head_eq) begin
        sum_nxt   = sum_sat;
        taken_nxt = taken_r | p_bit;
      end
    end

    case (st_r)
      ST_IDLE: begin
        // Apply push or close; drop everything once finished
        if (in_fire && !fin_r) begin
          if (push_ok) begin
            valid_nxt = valid_r | way_bit;
          end
          if (in_func == FUNC_CLOSE) begin
            closed_nxt = closed_r | way_bit;
          end
          st_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (lim_hit || (all_closed && !(|valid_r))) begin
          // Done without an entry
          if (slot_free) begin
            load     = 1'b1;
            res_done = 1'b1;
            fin_nxt  = 1'b1;
            st_nxt   = ST_IDLE;
          end
        end else if (pick_ok) begin
          rd_idx_nxt = '0;
          p_vld_nxt  = 1'b0;
          found_nxt  = 1'b0;
          taken_nxt  = '0;
          st_nxt     = ST_SCAN;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Issue one head read per cycle
        p_vld_nxt = 1'b1;
        p_idx_nxt = rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          st_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        p_vld_nxt = 1'b0;
        st_nxt    = ST_FINISH;
      end
      ST_FINISH: begin
        // Retire the consumed heads and hand out the merged item
        if (slot_free) begin
          load        = 1'b1;
          res_kl      = ml_r;
          res_kr      = mr_r;
          res_cnt     = sum_r;
          res_mask    = MASK_W'(mask_w);
          res_done    = fin_after;
          res_has     = 1'b1;
          valid_nxt   = valid_left;
          emitted_nxt = emit_inc[LIMIT_W-1:0];
          fin_nxt     = fin_after;
          st_nxt      = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: drop on take, raise on load
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      valid_r     <= '0;
      closed_r    <= '0;
      emitted_r   <= '0;
      fin_r       <= 1'b0;
      limit_r     <= LIMIT_RESET;
      rd_idx_r    <= '0;
      p_vld_r     <= 1'b0;
      found_r     <= 1'b0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      valid_r     <= valid_nxt;
      closed_r    <= closed_nxt;
      emitted_r   <= emitted_nxt;
      fin_r       <= fin_nxt;
      rd_idx_r    <= rd_idx_nxt;
      p_vld_r     <= p_vld_nxt;
      found_r     <= found_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_idx_r <= p_idx_nxt;
    ml_r    <= ml_nxt;
    mr_r    <= mr_nxt;
    sum_r   <= sum_nxt;
    if (load) begin
      out_kl_r   <= res_kl;
      out_kr_r   <= res_kr;
      out_cnt_r  <= res_cnt;
      out_mask_r <= res_mask;
      out_done_r <= res_done;
      out_has_r  <= res_has;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_major_key   = out_kl_r;
  assign out_minor_key   = out_kr_r;
  assign out_count       = out_cnt_r;
  assign out_refill_mask = out_mask_r;
  assign out_done_res    = out_done_r;
  assign out_has_entry   = out_has_r;

  // Checks
  `ASSERT_NEXT(a_accept_eval, clk, rst_n, in_fire && !fin_r, st_r == ST_EVAL)
  `ASSERT_IMPL(a_bare_done, clk, rst_n, out_valid_r && !out_has_r, out_done_r)
  `ASSERT_NEXT(a_fin_sticky, clk, rst_n, fin_r, fin_r)
  `ASSERT_IMPL(a_fin_idle, clk, rst_n, fin_r, st_r == ST_IDLE)

endmodule

`default_nettype wire

@@ rtl/kmdc_head_mem.sv @@
// Head entry memory: one write port, one registered read port.
// Depends on kmdc_pkg for the head entry type.
`default_nettype none

module kmdc_head_mem #(
  parameter int unsigned DEPTH = kmdc_pkg::DEF_WAYS,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire kmdc_pkg::head_t  wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output kmdc_pkg::head_t       rd_data
);
  import kmdc_pkg::*;

  head_t mem [DEPTH];
  head_t rd_data_r;

  // Write the pushed head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; rd_data holds its value while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
